### rtl/core/rbb_pkg.sv
package rbb_pkg;

    localparam int COORD_BITS  = 16;
    localparam int DIFF_BITS   = COORD_BITS + 1;
    localparam int MAG_BITS    = COORD_BITS;
    localparam int AREA_BITS   = 2 * MAG_BITS;
    localparam int EXT_BITS    = DIFF_BITS + 1;
    localparam int SCALAR_BITS = 35;
    localparam int OP_BITS     = 4;

    // opcodes
    localparam logic [OP_BITS-1:0] OP_AREA      = 4'd0;
    localparam logic [OP_BITS-1:0] OP_EXT_SUM   = 4'd1;
    localparam logic [OP_BITS-1:0] OP_UNION     = 4'd2;
    localparam logic [OP_BITS-1:0] OP_INTER     = 4'd3;
    localparam logic [OP_BITS-1:0] OP_UNION_AR  = 4'd4;
    localparam logic [OP_BITS-1:0] OP_INTER_AR  = 4'd5;
    localparam logic [OP_BITS-1:0] OP_DEAD      = 4'd6;
    localparam logic [OP_BITS-1:0] OP_OVERLAP   = 4'd7;
    localparam logic [OP_BITS-1:0] OP_EQUAL     = 4'd8;
    localparam logic [OP_BITS-1:0] OP_INIT      = 4'd9;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] min_x;
        logic signed [COORD_BITS-1:0] min_y;
        logic signed [COORD_BITS-1:0] max_x;
        logic signed [COORD_BITS-1:0] max_y;
    } t_box;

    // extents of one box along both axes
    typedef struct packed {
        logic signed [DIFF_BITS-1:0] dx;
        logic signed [DIFF_BITS-1:0] dy;
    } t_ext;

    // first stage result: boxes, extents and tests
    typedef struct packed {
        logic [OP_BITS-1:0]         op;
        t_box                       box;
        logic signed [EXT_BITS-1:0] ext_sum;
        logic                       flag;
        t_ext                       ext_a;
        t_ext                       ext_b;
        t_ext                       ext_u;
        t_ext                       ext_i;
    } t_geom;

    // second stage result: the four areas
    typedef struct packed {
        logic [OP_BITS-1:0]         op;
        t_box                       box;
        logic signed [EXT_BITS-1:0] ext_sum;
        logic                       flag;
        logic [AREA_BITS-1:0]       area_a;
        logic [AREA_BITS-1:0]       area_b;
        logic [AREA_BITS-1:0]       area_u;
        logic [AREA_BITS-1:0]       area_i;
    } t_area;

    function automatic logic signed [DIFF_BITS-1:0] diff(
        input logic signed [COORD_BITS-1:0] hi,
        input logic signed [COORD_BITS-1:0] lo
    );
        return DIFF_BITS'(hi) - DIFF_BITS'(lo);
    endfunction

    function automatic t_ext extents(input t_box b);
        t_ext e;
        e.dx = diff(b.max_x, b.min_x);
        e.dy = diff(b.max_y, b.min_y);
        return e;
    endfunction

    // magnitude of a difference; never exceeds the coordinate span
    function automatic logic [MAG_BITS-1:0] mag(input logic signed [DIFF_BITS-1:0] d);
        logic [DIFF_BITS-1:0] t;
        t = d[DIFF_BITS-1] ? (~d + 1'b1) : d;
        return t[MAG_BITS-1:0];
    endfunction

    function automatic logic signed [COORD_BITS-1:0] smin(
        input logic signed [COORD_BITS-1:0] a,
        input logic signed [COORD_BITS-1:0] b
    );
        return (a < b) ? a : b;
    endfunction

    function automatic logic signed [COORD_BITS-1:0] smax(
        input logic signed [COORD_BITS-1:0] a,
        input logic signed [COORD_BITS-1:0] b
    );
        return (a < b) ? b : a;
    endfunction

endpackage

### rtl/core/rbb_geom.sv
module rbb_geom (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic                                 i_valid,
    input  logic [rbb_pkg::OP_BITS-1:0]          i_opcode,
    input  rbb_pkg::t_box                        i_a,
    input  rbb_pkg::t_box                        i_b,
    output logic                                 o_valid,
    output rbb_pkg::t_geom                       o_geom
);

    rbb_pkg::t_box  ubox;
    rbb_pkg::t_box  ibox;
    rbb_pkg::t_ext  ext_a;
    rbb_pkg::t_geom n_geom;
    logic           overlap;
    logic           equal;
    logic           r_valid;
    rbb_pkg::t_geom r_geom;

    // union takes B alone when A is uninitialized
    always_comb begin
        if (i_a.min_x < 0) begin
            ubox = i_b;
        end else begin
            ubox.min_x = rbb_pkg::smin(i_a.min_x, i_b.min_x);
            ubox.min_y = rbb_pkg::smin(i_a.min_y, i_b.min_y);
            ubox.max_x = rbb_pkg::smax(i_a.max_x, i_b.max_x);
            ubox.max_y = rbb_pkg::smax(i_a.max_y, i_b.max_y);
        end
        ibox.min_x = rbb_pkg::smax(i_a.min_x, i_b.min_x);
        ibox.min_y = rbb_pkg::smax(i_a.min_y, i_b.min_y);
        ibox.max_x = rbb_pkg::smin(i_a.max_x, i_b.max_x);
        ibox.max_y = rbb_pkg::smin(i_a.max_y, i_b.max_y);
    end

    // tests
    assign overlap = !((i_b.min_x > i_a.max_x) || (i_b.max_x < i_a.min_x) ||
                       (i_b.min_y > i_a.max_y) || (i_b.max_y < i_a.min_y));
    assign equal   = (i_a == i_b);
    assign ext_a   = rbb_pkg::extents(i_a);

    always_comb begin
        n_geom.op      = i_opcode;
        n_geom.box     = '0;
        n_geom.flag    = 1'b0;
        n_geom.ext_sum = rbb_pkg::EXT_BITS'(ext_a.dx) + rbb_pkg::EXT_BITS'(ext_a.dy);
        n_geom.ext_a   = ext_a;
        n_geom.ext_b   = rbb_pkg::extents(i_b);
        n_geom.ext_u   = rbb_pkg::extents(ubox);
        n_geom.ext_i   = rbb_pkg::extents(ibox);
        case (i_opcode)
            rbb_pkg::OP_UNION:   n_geom.box  = ubox;
            rbb_pkg::OP_INTER:   n_geom.box  = ibox;
            rbb_pkg::OP_OVERLAP: n_geom.flag = overlap;
            rbb_pkg::OP_EQUAL:   n_geom.flag = equal;
            rbb_pkg::OP_INIT:    n_geom.flag = !i_a.min_x[rbb_pkg::COORD_BITS-1];
            default:             n_geom.flag = 1'b0;
        endcase
    end

    // stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_geom <= n_geom;
        end
    end

    assign o_valid = r_valid;
    assign o_geom  = r_geom;

endmodule

### rtl/core/rbb_area.sv
module rbb_area (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  rbb_pkg::t_geom i_geom,
    output logic           o_valid,
    output rbb_pkg::t_area o_area
);

    rbb_pkg::t_area n_area;
    logic           r_valid;
    rbb_pkg::t_area r_area;

    function automatic logic [rbb_pkg::AREA_BITS-1:0] area(input rbb_pkg::t_ext e);
        logic [rbb_pkg::AREA_BITS-1:0] mx;
        logic [rbb_pkg::AREA_BITS-1:0] my;
        mx = rbb_pkg::AREA_BITS'(rbb_pkg::mag(e.dx));
        my = rbb_pkg::AREA_BITS'(rbb_pkg::mag(e.dy));
        return mx * my;
    endfunction

    // four multipliers side by side
    always_comb begin
        n_area.op      = i_geom.op;
        n_area.box     = i_geom.box;
        n_area.ext_sum = i_geom.ext_sum;
        n_area.flag    = i_geom.flag;
        n_area.area_a  = area(i_geom.ext_a);
        n_area.area_b  = area(i_geom.ext_b);
        n_area.area_u  = area(i_geom.ext_u);
        n_area.area_i  = area(i_geom.ext_i);
    end

    // stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_area <= n_area;
        end
    end

    assign o_valid = r_valid;
    assign o_area  = r_area;

endmodule

### rtl/core/rbb_combine.sv
module rbb_combine (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  logic                                  i_valid,
    input  rbb_pkg::t_area                        i_area,
    output logic                                  o_valid,
    output rbb_pkg::t_box                         o_box,
    output logic signed [rbb_pkg::SCALAR_BITS-1:0] o_scalar,
    output logic                                  o_flag
);

    localparam int SB = rbb_pkg::SCALAR_BITS;

    logic signed [SB-1:0] dead;
    logic signed [SB-1:0] n_scalar;
    logic                 r_valid;
    rbb_pkg::t_box        r_box;
    logic signed [SB-1:0] r_scalar;
    logic                 r_flag;

    // dead space stays inside the scalar range, no saturation needed
    assign dead = SB'(i_area.area_u) - SB'(i_area.area_a) - SB'(i_area.area_b)
                + SB'(i_area.area_i);

    always_comb begin
        case (i_area.op)
            rbb_pkg::OP_AREA:     n_scalar = SB'(i_area.area_a);
            rbb_pkg::OP_EXT_SUM:  n_scalar = SB'(i_area.ext_sum);
            rbb_pkg::OP_UNION_AR: n_scalar = SB'(i_area.area_u);
            rbb_pkg::OP_INTER_AR: n_scalar = SB'(i_area.area_i);
            rbb_pkg::OP_DEAD:     n_scalar = dead;
            default:              n_scalar = '0;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_box    <= i_area.box;
            r_scalar <= n_scalar;
            r_flag   <= i_area.flag;
        end
    end

    assign o_valid  = r_valid;
    assign o_box    = r_box;
    assign o_scalar = r_scalar;
    assign o_flag   = r_flag;

endmodule

### rtl/core/rect_bounding_box_unit.sv
// Channel  Direction  Handshake          Payload
// in       input      i_valid / o_stall  i_opcode, i_a_*, i_b_*
// out      output     o_valid / i_stall  o_box_*, o_scalar_value, o_test_flag
//
// Three register stages: box and extent logic, area multipliers, combine and
// output register. One item per cycle is taken while o_stall is low.
// Reset is synchronous, active low, and clears the stage valid bits only.
// The stages advance together; a stalled full output holds the whole
// pipeline, and o_stall is then raised so nothing is dropped.
module rect_bounding_box_unit (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic [rbb_pkg::OP_BITS-1:0]            i_opcode,
    input  logic signed [rbb_pkg::COORD_BITS-1:0]  i_a_min_x,
    input  logic signed [rbb_pkg::COORD_BITS-1:0]  i_a_min_y,
    input  logic signed [rbb_pkg::COORD_BITS-1:0]  i_a_max_x,
    input  logic signed [rbb_pkg::COORD_BITS-1:0]  i_a_max_y,
    input  logic signed [rbb_pkg::COORD_BITS-1:0]  i_b_min_x,
    input  logic signed [rbb_pkg::COORD_BITS-1:0]  i_b_min_y,
    input  logic signed [rbb_pkg::COORD_BITS-1:0]  i_b_max_x,
    input  logic signed [rbb_pkg::COORD_BITS-1:0]  i_b_max_y,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic signed [rbb_pkg::COORD_BITS-1:0]  o_box_min_x,
    output logic signed [rbb_pkg::COORD_BITS-1:0]  o_box_min_y,
    output logic signed [rbb_pkg::COORD_BITS-1:0]  o_box_max_x,
    output logic signed [rbb_pkg::COORD_BITS-1:0]  o_box_max_y,
    output logic signed [rbb_pkg::SCALAR_BITS-1:0] o_scalar_value,
    output logic                                   o_test_flag
);

    logic           en;
    rbb_pkg::t_box  a_box;
    rbb_pkg::t_box  b_box;
    rbb_pkg::t_box  out_box;
    logic           geom_valid;
    rbb_pkg::t_geom geom;
    logic           area_valid;
    rbb_pkg::t_area area;

    // pipeline moves unless a finished item is held at the output
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    assign a_box = '{min_x: i_a_min_x, min_y: i_a_min_y, max_x: i_a_max_x, max_y: i_a_max_y};
    assign b_box = '{min_x: i_b_min_x, min_y: i_b_min_y, max_x: i_b_max_x, max_y: i_b_max_y};

    rbb_geom u_geom (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (i_valid),
        .i_opcode (i_opcode),
        .i_a      (a_box),
        .i_b      (b_box),
        .o_valid  (geom_valid),
        .o_geom   (geom)
    );

    rbb_area u_area (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (geom_valid),
        .i_geom  (geom),
        .o_valid (area_valid),
        .o_area  (area)
    );

    rbb_combine u_combine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (area_valid),
        .i_area   (area),
        .o_valid  (o_valid),
        .o_box    (out_box),
        .o_scalar (o_scalar_value),
        .o_flag   (o_test_flag)
    );

    assign o_box_min_x = out_box.min_x;
    assign o_box_min_y = out_box.min_y;
    assign o_box_max_x = out_box.max_x;
    assign o_box_max_y = out_box.max_y;

    // input is held back only by a full, stalled output
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a held output item");

    // a test result carries no scalar and no box
    a_flag_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_test_flag) |-> (o_scalar_value == 0 && out_box == '0))
        else $error("test flag set alongside other result fields");

    // a box result carries no scalar and no flag
    a_box_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && out_box != '0) |-> (o_scalar_value == 0 && !o_test_flag))
        else $error("box result set alongside other result fields");

    // a stalled output item stays put until it is taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(out_box) &&
                                  $stable(o_scalar_value) && $stable(o_test_flag)))
        else $error("stalled output item changed");

endmodule

### sim/bbox_checker.sv
// Watches both channels of the bounding-box unit, predicts one result per
// accepted item and compares it with the results that come out, in order.
module bbox_checker (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // input channel
    input  logic                                   i_in_valid,
    input  logic                                   i_in_stall,
    input  logic [rbb_pkg::OP_BITS-1:0]            i_opcode,
    input  rbb_pkg::t_box                          i_a,
    input  rbb_pkg::t_box                          i_b,
    // output channel
    input  logic                                   i_out_valid,
    input  logic                                   i_out_stall,
    input  rbb_pkg::t_box                          i_box,
    input  logic signed [rbb_pkg::SCALAR_BITS-1:0] i_scalar,
    input  logic                                   i_flag,
    // status for the top
    output int                                     o_err_count,
    output int                                     o_pending
);

    localparam longint SCALAR_TOP    = (longint'(1) <<< (rbb_pkg::SCALAR_BITS - 1)) - 1;
    localparam longint SCALAR_BOTTOM = -SCALAR_TOP - 1;

    typedef struct {
        rbb_pkg::t_box                         box;
        logic signed [rbb_pkg::SCALAR_BITS-1:0] scalar;
        logic                                  flag;
    } t_result;

    t_result bbox_due[$];
    t_result want;
    int      err_total  = 0;
    int      result_idx = 0;

    assign o_err_count = err_total;

    function automatic longint coord(input logic signed [rbb_pkg::COORD_BITS-1:0] c);
        return longint'(c);
    endfunction

    function automatic logic signed [rbb_pkg::COORD_BITS-1:0] pick_lo(
        input logic signed [rbb_pkg::COORD_BITS-1:0] p,
        input logic signed [rbb_pkg::COORD_BITS-1:0] q
    );
        return (p < q) ? p : q;
    endfunction

    function automatic logic signed [rbb_pkg::COORD_BITS-1:0] pick_hi(
        input logic signed [rbb_pkg::COORD_BITS-1:0] p,
        input logic signed [rbb_pkg::COORD_BITS-1:0] q
    );
        return (p < q) ? q : p;
    endfunction

    // absolute area, saturated to the positive scalar range
    function automatic longint abs_area(input rbb_pkg::t_box r);
        longint w;
        longint h;
        longint p;
        w = coord(r.max_x) - coord(r.min_x);
        h = coord(r.max_y) - coord(r.min_y);
        if (w < 0) w = -w;
        if (h < 0) h = -h;
        p = w * h;
        if (p > SCALAR_TOP) p = SCALAR_TOP;
        return p;
    endfunction

    // an uninitialized A (negative min x) leaves B alone
    function automatic rbb_pkg::t_box merge_box(input rbb_pkg::t_box a, input rbb_pkg::t_box b);
        rbb_pkg::t_box c;
        if (coord(a.min_x) < 0) return b;
        c.min_x = pick_lo(a.min_x, b.min_x);
        c.min_y = pick_lo(a.min_y, b.min_y);
        c.max_x = pick_hi(a.max_x, b.max_x);
        c.max_y = pick_hi(a.max_y, b.max_y);
        return c;
    endfunction

    // no validity check: disjoint boxes give an inverted box
    function automatic rbb_pkg::t_box common_box(input rbb_pkg::t_box a, input rbb_pkg::t_box b);
        rbb_pkg::t_box c;
        c.min_x = pick_hi(a.min_x, b.min_x);
        c.min_y = pick_hi(a.min_y, b.min_y);
        c.max_x = pick_lo(a.max_x, b.max_x);
        c.max_y = pick_lo(a.max_y, b.max_y);
        return c;
    endfunction

    function automatic t_result predict_bbox(
        input logic [rbb_pkg::OP_BITS-1:0] op,
        input rbb_pkg::t_box               a,
        input rbb_pkg::t_box               b
    );
        t_result r;
        longint  s;
        logic    apart;
        r.box  = '0;
        r.flag = 1'b0;
        s      = 0;
        case (op)
            rbb_pkg::OP_AREA: begin
                s = abs_area(a);
            end
            rbb_pkg::OP_EXT_SUM: begin
                s = (coord(a.max_x) - coord(a.min_x)) + (coord(a.max_y) - coord(a.min_y));
            end
            rbb_pkg::OP_UNION: begin
                r.box = merge_box(a, b);
            end
            rbb_pkg::OP_INTER: begin
                r.box = common_box(a, b);
            end
            rbb_pkg::OP_UNION_AR: begin
                s = abs_area(merge_box(a, b));
            end
            rbb_pkg::OP_INTER_AR: begin
                s = abs_area(common_box(a, b));
            end
            rbb_pkg::OP_DEAD: begin
                s = abs_area(merge_box(a, b)) - abs_area(a) - abs_area(b)
                    + abs_area(common_box(a, b));
            end
            rbb_pkg::OP_OVERLAP: begin
                apart = (coord(b.min_x) > coord(a.max_x)) || (coord(b.max_x) < coord(a.min_x))
                     || (coord(b.min_y) > coord(a.max_y)) || (coord(b.max_y) < coord(a.min_y));
                r.flag = !apart;
            end
            rbb_pkg::OP_EQUAL: begin
                r.flag = (a == b);
            end
            rbb_pkg::OP_INIT: begin
                r.flag = (coord(a.min_x) >= 0);
            end
            default: begin
            end
        endcase
        if (s > SCALAR_TOP) s = SCALAR_TOP;
        if (s < SCALAR_BOTTOM) s = SCALAR_BOTTOM;
        r.scalar = s[rbb_pkg::SCALAR_BITS-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint exp_v);
        $display("checker: result %0d %s: got %0d, want %0d", result_idx, what, got, exp_v);
        err_total++;
    endtask

    // results are checked before the same edge's item is queued
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_out_valid && !i_out_stall) begin
                if (bbox_due.size() == 0) begin
                    report_mismatch("unexpected result, scalar", i_scalar, 0);
                end else begin
                    want = bbox_due.pop_front();
                    if (i_box.min_x !== want.box.min_x)
                        report_mismatch("box_min_x", i_box.min_x, want.box.min_x);
                    if (i_box.min_y !== want.box.min_y)
                        report_mismatch("box_min_y", i_box.min_y, want.box.min_y);
                    if (i_box.max_x !== want.box.max_x)
                        report_mismatch("box_max_x", i_box.max_x, want.box.max_x);
                    if (i_box.max_y !== want.box.max_y)
                        report_mismatch("box_max_y", i_box.max_y, want.box.max_y);
                    if (i_scalar !== want.scalar)
                        report_mismatch("scalar_value", i_scalar, want.scalar);
                    if (i_flag !== want.flag)
                        report_mismatch("test_flag", i_flag, want.flag);
                end
                result_idx++;
            end
            if (i_in_valid && !i_in_stall)
                bbox_due.push_back(predict_bbox(i_opcode, i_a, i_b));
            o_pending <= bbox_due.size();
        end
    end

endmodule

### sim/testbench.sv
// Drives rectangle pairs into the bounding-box unit, stalls its output at
// random and gives the verdict from the checker's error count.
module testbench;

    localparam logic [rbb_pkg::OP_BITS-1:0] OP_SPARE_FIRST = 4'd10;
    localparam logic [rbb_pkg::OP_BITS-1:0] OP_SPARE_LAST  = 4'd15;
    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_ITEMS = 410;
    localparam int TAIL_CYCLES  = 12;

    typedef struct {
        logic [rbb_pkg::OP_BITS-1:0] op;
        rbb_pkg::t_box               a;
        rbb_pkg::t_box               b;
    } t_req;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // input channel
    logic                        in_valid = 1'b0;
    logic                        in_stall;
    logic [rbb_pkg::OP_BITS-1:0] req_op   = '0;
    rbb_pkg::t_box               req_a    = '0;
    rbb_pkg::t_box               req_b    = '0;

    // output channel
    logic                                   out_valid;
    logic                                   out_stall = 1'b0;
    rbb_pkg::t_box                          res_box;
    logic signed [rbb_pkg::SCALAR_BITS-1:0] res_scalar;
    logic                                   res_flag;

    int err_count;
    int pending;
    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;
    int idle_cycles  = 0;

    always #2 clk = ~clk;

    rect_bounding_box_unit dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_valid        (in_valid),
        .o_stall        (in_stall),
        .i_opcode       (req_op),
        .i_a_min_x      (req_a.min_x),
        .i_a_min_y      (req_a.min_y),
        .i_a_max_x      (req_a.max_x),
        .i_a_max_y      (req_a.max_y),
        .i_b_min_x      (req_b.min_x),
        .i_b_min_y      (req_b.min_y),
        .i_b_max_x      (req_b.max_x),
        .i_b_max_y      (req_b.max_y),
        .o_valid        (out_valid),
        .i_stall        (out_stall),
        .o_box_min_x    (res_box.min_x),
        .o_box_min_y    (res_box.min_y),
        .o_box_max_x    (res_box.max_x),
        .o_box_max_y    (res_box.max_y),
        .o_scalar_value (res_scalar),
        .o_test_flag    (res_flag)
    );

    bbox_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_opcode    (req_op),
        .i_a         (req_a),
        .i_b         (req_b),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_box       (res_box),
        .i_scalar    (res_scalar),
        .i_flag      (res_flag),
        .o_err_count (err_count),
        .o_pending   (pending)
    );

    // receiver back-pressure
    always @(posedge clk) begin
        out_stall <= rst_n && ($urandom_range(99) < rcv_idle_pct);
    end

    // watchdog: cycles with no item moving on either channel
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("testbench: done, errors");
                $finish;
            end
        end
    end

    function automatic t_req mk_req(
        input logic [rbb_pkg::OP_BITS-1:0] op,
        input int ax0, input int ay0, input int ax1, input int ay1,
        input int bx0, input int by0, input int bx1, input int by1
    );
        t_req r;
        r.op = op;
        r.a  = {16'(ax0), 16'(ay0), 16'(ax1), 16'(ay1)};
        r.b  = {16'(bx0), 16'(by0), 16'(bx1), 16'(by1)};
        return r;
    endfunction

    // coordinates lean toward the extremes and small values
    function automatic logic signed [rbb_pkg::COORD_BITS-1:0] rand_coord();
        case ($urandom_range(9))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return '0;
            3: return '1;
            4, 5: return 16'(int'($urandom_range(40)) - 20);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic signed [rbb_pkg::COORD_BITS-1:0] nudge(
        input logic signed [rbb_pkg::COORD_BITS-1:0] c
    );
        return c + 16'(int'($urandom_range(20)) - 10);
    endfunction

    function automatic rbb_pkg::t_box rand_box(input logic ordered);
        rbb_pkg::t_box r;
        logic signed [rbb_pkg::COORD_BITS-1:0] t;
        r = {rand_coord(), rand_coord(), rand_coord(), rand_coord()};
        if (ordered && r.min_x > r.max_x) begin
            t = r.min_x; r.min_x = r.max_x; r.max_x = t;
        end
        if (ordered && r.min_y > r.max_y) begin
            t = r.min_y; r.min_y = r.max_y; r.max_y = t;
        end
        return r;
    endfunction

    function automatic t_req rand_req();
        t_req r;
        logic [rbb_pkg::COORD_BITS-1:0] flip;
        int pick;
        if ($urandom_range(99) < 8)
            r.op = OP_SPARE_FIRST + 4'($urandom_range(OP_SPARE_LAST - OP_SPARE_FIRST));
        else
            r.op = 4'($urandom_range(rbb_pkg::OP_INIT));
        r.a = rand_box($urandom_range(99) < 75);
        if ($urandom_range(99) < 20) r.a.min_x[rbb_pkg::COORD_BITS-1] = 1'b1;
        pick = $urandom_range(99);
        flip = 16'(1) << $urandom_range(rbb_pkg::COORD_BITS - 1);
        if (pick < 15) begin
            r.b = r.a;
        end else if (pick < 25) begin
            // equal but for one bit of one coordinate
            r.b = r.a;
            case ($urandom_range(3))
                0: r.b.min_x = r.b.min_x ^ flip;
                1: r.b.min_y = r.b.min_y ^ flip;
                2: r.b.max_x = r.b.max_x ^ flip;
                default: r.b.max_y = r.b.max_y ^ flip;
            endcase
        end else if (pick < 60) begin
            // close to A: touching, nested or just apart
            r.b = {nudge(r.a.min_x), nudge(r.a.min_y), nudge(r.a.max_x), nudge(r.a.max_y)};
        end else begin
            r.b = rand_box($urandom_range(99) < 75);
        end
        return r;
    endfunction

    // holds valid across back-to-back items; only drops it for a gap
    task automatic send_req(input t_req r);
        if ($urandom_range(99) < snd_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < snd_idle_pct) @(posedge clk);
        end
        req_op   <= r.op;
        req_a    <= r.a;
        req_b    <= r.b;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic send_random(input int count);
        for (int k = 0; k < count; k++) send_req(rand_req());
    endtask

    initial begin
        t_req directed[$];

        // extremes, each operation and the special cases
        directed.push_back(mk_req(rbb_pkg::OP_AREA, -32768, -32768, 32767, 32767, 0, 0, 0, 0));
        directed.push_back(mk_req(rbb_pkg::OP_AREA, 32767, 32767, -32768, -32768, 1, 2, 3, 4));
        directed.push_back(mk_req(rbb_pkg::OP_AREA, 5, 5, 5, 100, 0, 0, 9, 9));
        directed.push_back(mk_req(rbb_pkg::OP_EXT_SUM, -32768, -32768, 32767, 32767,
                                  0, 0, 0, 0));
        directed.push_back(mk_req(rbb_pkg::OP_EXT_SUM, 32767, 32767, -32768, -32768,
                                  0, 0, 0, 0));
        directed.push_back(mk_req(rbb_pkg::OP_UNION, 0, 0, 10, 10, -5, 3, 20, 8));
        directed.push_back(mk_req(rbb_pkg::OP_UNION, -1, 0, 10, 10, 3, 4, 5, 6));
        directed.push_back(mk_req(rbb_pkg::OP_INTER, 0, 0, 10, 10, 5, 5, 15, 15));
        directed.push_back(mk_req(rbb_pkg::OP_INTER, 0, 0, 10, 10, 20, 30, 40, 50));
        directed.push_back(mk_req(rbb_pkg::OP_UNION_AR, 0, -32768, 0, 0,
                                  -32768, 0, 32767, 32767));
        directed.push_back(mk_req(rbb_pkg::OP_UNION_AR, -32768, -32768, 0, 0,
                                  1, 1, 32767, 32767));
        directed.push_back(mk_req(rbb_pkg::OP_INTER_AR, 0, 0, 10, 10, 20, 30, 40, 50));
        directed.push_back(mk_req(rbb_pkg::OP_INTER_AR, -32768, -32768, 32767, 32767,
                                  -32768, -32768, 32767, 32767));
        directed.push_back(mk_req(rbb_pkg::OP_DEAD, 0, -32768, 0, 0, 1, 1, 32767, 32767));
        directed.push_back(mk_req(rbb_pkg::OP_DEAD, -32768, -32768, 0, 0,
                                  1, 1, 32767, 32767));
        directed.push_back(mk_req(rbb_pkg::OP_DEAD, 0, 0, 10, 10, 20, 30, 40, 50));
        directed.push_back(mk_req(rbb_pkg::OP_OVERLAP, 0, 0, 10, 10, 10, 10, 20, 20));
        directed.push_back(mk_req(rbb_pkg::OP_OVERLAP, 0, 0, 10, 10, 0, 11, 10, 20));
        directed.push_back(mk_req(rbb_pkg::OP_OVERLAP, 0, 0, 10, 10, -20, -20, -1, 5));
        directed.push_back(mk_req(rbb_pkg::OP_EQUAL, -32768, 7, 32767, -9,
                                  -32768, 7, 32767, -9));
        directed.push_back(mk_req(rbb_pkg::OP_EQUAL, 1, 2, 3, 4, 1, 2, 3, 5));
        directed.push_back(mk_req(rbb_pkg::OP_INIT, 0, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(mk_req(rbb_pkg::OP_INIT, -32768, 1, 2, 3, 4, 5, 6, 7));
        directed.push_back(mk_req(OP_SPARE_FIRST, 1, 2, 30, 40, 5, 6, 70, 80));
        directed.push_back(mk_req(OP_SPARE_LAST, -1, -1, -1, -1, -1, -1, -1, -1));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // phase 1: sender idles a little, receiver a lot
        snd_idle_pct = 21;
        rcv_idle_pct <= 66;
        foreach (directed[k]) send_req(directed[k]);
        send_random(RANDOM_ITEMS);

        // phase 2: the other way round
        snd_idle_pct = 66;
        rcv_idle_pct <= 21;
        send_random(RANDOM_ITEMS);

        // phase 3: full rate on both sides
        snd_idle_pct = 0;
        rcv_idle_pct <= 0;
        send_random(RANDOM_ITEMS);
        in_valid <= 1'b0;

        // drain, then wait out the tail before the verdict
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (err_count == 0 && pending == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

### rect_bounding_box_unit.f
rtl/core/rbb_pkg.sv
rtl/core/rbb_geom.sv
rtl/core/rbb_area.sv
rtl/core/rbb_combine.sv
rtl/core/rect_bounding_box_unit.sv
sim/bbox_checker.sv
sim/testbench.sv
